FILE: rtl/dpalu_pkg.sv
package dpalu_pkg;

    // operand and result word
    typedef logic [31:0] word_t;

    // condition flags, N in bit 3 down to V in bit 0
    typedef logic [3:0] flags_t;

    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    // mask of the 8-bit immediate field
    localparam logic [7:0] IMM8_MASK = 8'hFF;

    // largest opcode value
    localparam logic [3:0] OPCODE_MAX = 4'd15;

    // data-processing opcodes
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } opcode_t;

    // barrel shifter types
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_t;

endpackage

FILE: rtl/data_processing_alu_with_shifter.sv
// Data-processing ALU with barrel shifter. Each transfer on the input channel carries one
// 32-bit operation (16 opcodes, rotated 8-bit immediate or shifted register as the second
// operand) and gives exactly one result transfer, with the result word, its write enable
// and the new NZCV flags. The block is a two-register pipeline: input register, one
// combinational pass through shifter and 33-bit adder, result register. It takes one
// operation every cycle unless in_stall is high; a result passes the input register and
// then the result register, is presented on the outputs and transfers at the next edge at
// the earliest. The input is stalled only while a result is held in the result register
// and the output is stalled with the input register also full.
module data_processing_alu_with_shifter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        req_type,
    input  logic              update_flags,
    input  logic              dest_is_pc,
    input  logic              use_immediate,
    input  logic [11:0]       operand_encoding,
    input  dpalu_pkg::word_t  first_value,
    input  dpalu_pkg::word_t  shifted_value,
    input  logic [7:0]        shift_reg_byte,
    input  dpalu_pkg::flags_t flags_in,
    output logic              out_valid,
    input  logic              out_stall,
    output dpalu_pkg::word_t  result_value,
    output logic              write_result,
    output dpalu_pkg::flags_t flags_out,
    output logic              flags_changed
);
    import dpalu_pkg::*;

    // input register
    logic        in_vld_reg;
    opcode_t     op_reg;
    logic        sbit_reg;
    logic        to_pc_reg;
    logic        imm_reg;
    logic [11:0] enc_reg;
    word_t       a_reg;
    word_t       rm_reg;
    logic [7:0]  sbyte_reg;
    flags_t      fl_reg;

    // result register
    logic        out_vld_reg;
    word_t       res_reg;
    logic        wr_reg;
    flags_t      fout_reg;
    logic        fchg_reg;

    // next values of the result register
    word_t       res_next;
    logic        wr_next;
    flags_t      fout_next;
    logic        fchg_next;

    logic        out_advance;

    // result register moves unless it holds a stalled result
    assign out_advance = !out_vld_reg || !out_stall;
    assign in_stall    = in_vld_reg && !out_advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg    <= opcode_t'(req_type & OPCODE_MAX);
            sbit_reg  <= update_flags;
            to_pc_reg <= dest_is_pc;
            imm_reg   <= use_immediate;
            enc_reg   <= operand_encoding;
            a_reg     <= first_value;
            rm_reg    <= shifted_value;
            sbyte_reg <= shift_reg_byte;
            fl_reg    <= flags_in;
        end
    end

    // second operand: rotated immediate or barrel-shifted register
    logic        cin;
    logic        vin;
    word_t       b_op;
    logic        sh_c;
    logic [4:0]  rot_amt;
    word_t       imm_word;
    logic [63:0] imm_dbl;
    logic        by_imm;
    shift_t      sh_type;
    logic [7:0]  amt;
    logic [4:0]  amt_lo;
    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [63:0] ror_dbl;
    word_t       ror_word;

    assign cin      = fl_reg[FLAG_C];
    assign vin      = fl_reg[FLAG_V];
    assign rot_amt  = {enc_reg[11:8], 1'b0};
    assign imm_word = {24'd0, enc_reg[7:0] & IMM8_MASK};
    assign imm_dbl  = {imm_word, imm_word} >> rot_amt;
    assign by_imm   = !enc_reg[4];
    assign sh_type  = shift_t'(enc_reg[6:5]);
    assign amt      = by_imm ? {3'd0, enc_reg[11:7]} : sbyte_reg;
    assign amt_lo   = amt[4:0];
    assign lsl_wide = {1'b0, rm_reg} << amt_lo;
    assign lsr_wide = {rm_reg, 1'b0} >> amt_lo;
    assign asr_wide = 33'($signed({rm_reg, 1'b0}) >>> amt_lo);
    assign ror_dbl  = {rm_reg, rm_reg} >> amt_lo;
    assign ror_word = ror_dbl[31:0];

    always_comb
    begin
        b_op = rm_reg;
        sh_c = cin;
        if (imm_reg)
        begin
            b_op = imm_dbl[31:0];
            sh_c = (rot_amt == 5'd0) ? cin : imm_dbl[31];
        end
        else if (by_imm && amt == 8'd0)
        begin
            // immediate amount zero: lsr/asr by 32, ror becomes rrx
            unique case (sh_type)
                SH_LSL:
                begin
                    b_op = rm_reg;
                    sh_c = cin;
                end
                SH_LSR:
                begin
                    b_op = '0;
                    sh_c = rm_reg[31];
                end
                SH_ASR:
                begin
                    b_op = {32{rm_reg[31]}};
                    sh_c = rm_reg[31];
                end
                SH_ROR:
                begin
                    b_op = {cin, rm_reg[31:1]};
                    sh_c = rm_reg[0];
                end
                default:
                begin
                    b_op = rm_reg;
                    sh_c = cin;
                end
            endcase
        end
        else if (amt == 8'd0)
        begin
            b_op = rm_reg;
            sh_c = cin;
        end
        else
        begin
            unique case (sh_type)
                SH_LSL:
                begin
                    if (amt < 8'd32)
                    begin
                        b_op = lsl_wide[31:0];
                        sh_c = lsl_wide[32];
                    end
                    else
                    begin
                        b_op = '0;
                        sh_c = (amt == 8'd32) ? rm_reg[0] : 1'b0;
                    end
                end
                SH_LSR:
                begin
                    if (amt < 8'd32)
                    begin
                        b_op = lsr_wide[32:1];
                        sh_c = lsr_wide[0];
                    end
                    else
                    begin
                        b_op = '0;
                        sh_c = (amt == 8'd32) ? rm_reg[31] : 1'b0;
                    end
                end
                SH_ASR:
                begin
                    if (amt < 8'd32)
                    begin
                        b_op = asr_wide[32:1];
                        sh_c = asr_wide[0];
                    end
                    else
                    begin
                        b_op = {32{rm_reg[31]}};
                        sh_c = rm_reg[31];
                    end
                end
                SH_ROR:
                begin
                    b_op = ror_word;
                    sh_c = ror_word[31];
                end
                default:
                begin
                    b_op = rm_reg;
                    sh_c = cin;
                end
            endcase
        end
    end

    // adder operand selection
    word_t       add_x;
    word_t       add_y;
    logic        add_ci;
    logic [32:0] add_sum;
    word_t       add_r;
    logic        add_v;

    always_comb
    begin
        add_x  = a_reg;
        add_y  = b_op;
        add_ci = 1'b0;
        unique case (op_reg) inside
            OP_SUB, OP_CMP:
            begin
                add_x  = a_reg;
                add_y  = ~b_op;
                add_ci = 1'b1;
            end
            OP_RSB:
            begin
                add_x  = b_op;
                add_y  = ~a_reg;
                add_ci = 1'b1;
            end
            OP_ADC:
            begin
                add_x  = a_reg;
                add_y  = b_op;
                add_ci = cin;
            end
            OP_SBC:
            begin
                add_x  = a_reg;
                add_y  = ~b_op;
                add_ci = cin;
            end
            OP_RSC:
            begin
                add_x  = b_op;
                add_y  = ~a_reg;
                add_ci = cin;
            end
            default:
            begin
                add_x  = a_reg;
                add_y  = b_op;
                add_ci = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};
    assign add_r   = add_sum[31:0];
    assign add_v   = ((add_x[31] ^ add_r[31]) & (add_y[31] ^ add_r[31]));

    // result and flags
    word_t  alu_r;
    logic   alu_c;
    logic   alu_v;
    logic   is_test;
    logic   upd;
    flags_t nf;

    always_comb
    begin
        alu_r = add_r;
        alu_c = add_sum[32];
        alu_v = add_v;
        unique case (op_reg) inside
            OP_AND, OP_TST:
            begin
                alu_r = a_reg & b_op;
                alu_c = sh_c;
                alu_v = vin;
            end
            OP_EOR, OP_TEQ:
            begin
                alu_r = a_reg ^ b_op;
                alu_c = sh_c;
                alu_v = vin;
            end
            OP_ORR:
            begin
                alu_r = a_reg | b_op;
                alu_c = sh_c;
                alu_v = vin;
            end
            OP_MOV:
            begin
                alu_r = b_op;
                alu_c = sh_c;
                alu_v = vin;
            end
            OP_BIC:
            begin
                alu_r = a_reg & ~b_op;
                alu_c = sh_c;
                alu_v = vin;
            end
            OP_MVN:
            begin
                alu_r = ~b_op;
                alu_c = sh_c;
                alu_v = vin;
            end
            default:
            begin
                alu_r = add_r;
                alu_c = add_sum[32];
                alu_v = add_v;
            end
        endcase
    end

    assign is_test = (op_reg == OP_TST) || (op_reg == OP_TEQ) ||
                     (op_reg == OP_CMP) || (op_reg == OP_CMN);
    assign upd     = is_test || (sbit_reg && !to_pc_reg);
    assign nf      = {alu_r[31], (alu_r == 32'd0), alu_c, alu_v};

    assign res_next  = is_test ? '0 : alu_r;
    assign wr_next   = !is_test;
    assign fout_next = upd ? nf : fl_reg;
    assign fchg_next = upd;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_vld_reg)
        begin
            res_reg  <= res_next;
            wr_reg   <= wr_next;
            fout_reg <= fout_next;
            fchg_reg <= fchg_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign result_value  = res_reg;
    assign write_result  = wr_reg;
    assign flags_out     = fout_reg;
    assign flags_changed = fchg_reg;

endmodule

FILE: rtl/dpalu_checker.sv
module dpalu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input dpalu_pkg::word_t  result_value,
    input logic              write_result,
    input dpalu_pkg::flags_t flags_out,
    input logic              flags_changed
);
    import dpalu_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value) &&
        $stable(write_result) && $stable(flags_out) && $stable(flags_changed))
        else $error("stalled result changed");

    // input is held back only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    // compare and test ops give a zero result word
    a_test_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_result |-> result_value == '0)
        else $error("test op produced a nonzero result");

    // compare and test ops always update the flags
    a_test_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_result |-> flags_changed)
        else $error("test op left flags unchanged");

endmodule

bind data_processing_alu_with_shifter dpalu_checker u_dpalu_checker (.*);
